### src/mfh_pkg.sv
// Package: payload, command and configuration types shared by the median filter.
package mfh_pkg;

  localparam int CHAN_W   = 3;
  localparam int SAMPLE_W = 12;
  localparam int LEVEL_W  = 9;
  localparam int SLOT_W   = 5;
  localparam int REM_W    = 3;

  localparam logic [3:0] HYST_HIGH_RESET = 4'd6;
  localparam logic [2:0] HYST_LOW_RESET  = 3'd1;

  typedef struct packed {
    logic                opcode;
    logic [CHAN_W-1:0]   chan_sel;
    logic [SAMPLE_W-1:0] sample_in;
    logic                end_of_scan;
  } in_item_t;

  typedef struct packed {
    logic [CHAN_W-1:0]  chan_out;
    logic [LEVEL_W-1:0] level_out;
    logic               last_out;
  } out_item_t;

  typedef struct packed {
    logic                is_filter;
    logic                write;
    logic [CHAN_W-1:0]   chan;
    logic [SLOT_W-1:0]   slot;
    logic [SAMPLE_W-1:0] sample;
  } cmd_t;

  typedef struct packed {
    logic [3:0] hyst_high;
    logic [2:0] hyst_low;
  } cfg_t;

  localparam logic OP_STORE  = 1'b0;
  localparam logic OP_FILTER = 1'b1;

endpackage

### src/mfh_ram.sv
// Generic single-write, single-read RAM with registered read data.
module mfh_ram #(
  parameter int WIDTH = 12,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

### src/mfh_front.sv
// Front end: accepts input items, tracks the shared write slot, issues commands.
module mfh_front import mfh_pkg::*; #(
  parameter int CHANNELS = 2,
  parameter int WINDOW   = 8
) (
  input  logic     clk,
  input  logic     rst,
  input  logic     req_valid,
  output logic     req_ready,
  input  in_item_t req,
  input  logic     q_full,
  output logic     q_push,
  output cmd_t     q_cmd
);

  localparam int IW = (WINDOW > 1) ? $clog2(WINDOW) : 1;

  logic [IW-1:0] write_slot;
  logic [IW-1:0] write_slot_next;

  assign req_ready = !q_full;
  assign q_push    = req_valid && !q_full;

  always_comb begin
    q_cmd.is_filter = (req.opcode == OP_FILTER);
    q_cmd.write     = (req.opcode == OP_STORE) &&
                      ({1'b0, req.chan_sel} < (CHAN_W+1)'(CHANNELS));
    q_cmd.chan      = req.chan_sel;
    q_cmd.slot      = SLOT_W'(write_slot);
    q_cmd.sample    = req.sample_in;
  end

  always_comb begin
    write_slot_next = write_slot;
    if (q_push && req.opcode == OP_STORE && req.end_of_scan) begin
      if (write_slot == IW'(WINDOW - 1)) begin
        write_slot_next = '0;
      end else begin
        write_slot_next = write_slot + IW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      write_slot <= '0;
    end else begin
      write_slot <= write_slot_next;
    end
  end

endmodule

### src/mfh_queue.sv
// Short command queue between the front end and the filter engine.
module mfh_queue import mfh_pkg::*; #(
  parameter int DEPTH = 4
) (
  input  logic clk,
  input  logic rst,
  input  logic push,
  input  cmd_t push_cmd,
  output logic full,
  input  logic pop,
  output logic ready_out,
  output cmd_t head
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int NW = $clog2(DEPTH + 1);

  cmd_t          entries [DEPTH];
  logic [PW-1:0] wr_ptr;
  logic [PW-1:0] rd_ptr;
  logic [NW-1:0] count;
  logic          do_push;
  logic          do_pop;

  assign full      = (count == NW'(DEPTH));
  assign ready_out = (count != '0);
  assign head      = entries[rd_ptr];
  assign do_push   = push && !full;
  assign do_pop    = pop && ready_out;

  always_ff @(posedge clk) begin
    if (do_push) begin
      entries[wr_ptr] <= push_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PW'(DEPTH - 1)) ? '0 : wr_ptr + PW'(1);
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PW'(DEPTH - 1)) ? '0 : rd_ptr + PW'(1);
      end
      unique case ({do_push, do_pop})
        2'b10:   count <= count + NW'(1);
        2'b01:   count <= count - NW'(1);
        default: count <= count;
      endcase
    end
  end

endmodule

### src/mfh_back.sv
// Filter engine: sample store, rank-based median search, hysteresis and result register.
module mfh_back import mfh_pkg::*; #(
  parameter int CHANNELS = 2,
  parameter int WINDOW   = 8
) (
  input  logic      clk,
  input  logic      rst,
  input  cfg_t      cfg,
  input  logic      q_ready,
  input  cmd_t      q_head,
  output logic      q_pop,
  output logic      rsp_valid,
  input  logic      rsp_ready,
  output out_item_t rsp
);

  localparam int IW    = (WINDOW > 1) ? $clog2(WINDOW) : 1;
  localparam int CW    = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam int AW    = CW + IW;
  localparam int DEPTH = 1 << AW;
  localparam int NW    = $clog2(WINDOW + 1) + 1;
  localparam logic [NW-1:0] MED_RANK = NW'(WINDOW / 2);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_CAND  = 3'd1;
  localparam logic [2:0] S_CANDW = 3'd2;
  localparam logic [2:0] S_SWEEP = 3'd3;
  localparam logic [2:0] S_CHECK = 3'd4;
  localparam logic [2:0] S_EMIT  = 3'd5;

  logic [2:0]          state;
  logic [2:0]          state_next;
  logic [CW-1:0]       chan;
  logic [IW-1:0]       cand_idx;
  logic [IW-1:0]       sweep_idx;
  logic [SAMPLE_W-1:0] cand;
  logic [NW-1:0]       n_less;
  logic [NW-1:0]       n_equal;
  logic [LEVEL_W-1:0]  held [CHANNELS];
  logic [DEPTH-1:0]    vld;
  logic                rd_vld;
  logic [SAMPLE_W-1:0] ram_rdata;
  logic [SAMPLE_W-1:0] rd_sample;
  logic [AW-1:0]       raddr;
  logic [AW-1:0]       waddr;
  logic                we;
  logic                found;
  logic [LEVEL_W-1:0]  med_level;
  logic [REM_W-1:0]    med_rem;
  logic [LEVEL_W-1:0]  held_cur;
  logic [LEVEL_W-1:0]  held_new;
  logic                emit_go;

  assign waddr     = {q_head.chan[CW-1:0], q_head.slot[IW-1:0]};
  assign we        = (state == S_IDLE) && q_ready && !q_head.is_filter && q_head.write;
  assign rd_sample = rd_vld ? ram_rdata : '0;
  assign found     = (n_less <= MED_RANK) && (MED_RANK < n_less + n_equal);
  assign med_level = cand[SAMPLE_W-1:REM_W];
  assign med_rem   = cand[REM_W-1:0];
  assign held_cur  = held[chan];
  assign emit_go   = (state == S_EMIT) && (!rsp_valid || rsp_ready);
  assign q_pop     = (state == S_IDLE) && q_ready;

  always_comb begin
    unique case (state)
      S_CAND:  raddr = {chan, cand_idx};
      S_CANDW: raddr = {chan, IW'(0)};
      default: raddr = {chan, sweep_idx + IW'(1)};
    endcase
  end

  always_comb begin
    priority if (held_cur > med_level && {1'b0, med_rem} < cfg.hyst_high) begin
      held_new = med_level;
    end else if (held_cur < med_level && med_rem > cfg.hyst_low) begin
      held_new = med_level;
    end else begin
      held_new = held_cur;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE:  if (q_ready && q_head.is_filter) state_next = S_CAND;
      S_CAND:  state_next = S_CANDW;
      S_CANDW: state_next = S_SWEEP;
      S_SWEEP: if (sweep_idx == IW'(WINDOW - 1)) state_next = S_CHECK;
      S_CHECK: state_next = found ? S_EMIT : S_CAND;
      S_EMIT:  if (emit_go) state_next = (chan == CW'(CHANNELS - 1)) ? S_IDLE : S_CAND;
      default: state_next = S_IDLE;
    endcase
  end

  mfh_ram #(
    .WIDTH (SAMPLE_W),
    .DEPTH (DEPTH)
  ) u_store (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (q_head.sample),
    .raddr (raddr),
    .rdata (ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      vld    <= '0;
      rd_vld <= 1'b0;
    end else begin
      if (we) begin
        vld[waddr] <= 1'b1;
      end
      rd_vld <= vld[raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (emit_go) begin
      rsp_valid <= 1'b1;
    end else if (rsp_ready) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      chan      <= '0;
      cand_idx  <= '0;
      sweep_idx <= '0;
      n_less    <= '0;
      n_equal   <= '0;
      for (int c = 0; c < CHANNELS; c++) begin
        held[c] <= '0;
      end
    end else begin
      state <= state_next;
      unique case (state)
        S_IDLE: begin
          chan     <= '0;
          cand_idx <= '0;
        end
        S_CANDW: begin
          cand      <= rd_sample;
          sweep_idx <= '0;
          n_less    <= '0;
          n_equal   <= '0;
        end
        S_SWEEP: begin
          if (rd_sample < cand) begin
            n_less <= n_less + NW'(1);
          end
          if (rd_sample == cand) begin
            n_equal <= n_equal + NW'(1);
          end
          sweep_idx <= sweep_idx + IW'(1);
        end
        S_CHECK: begin
          if (!found) begin
            cand_idx <= cand_idx + IW'(1);
          end
        end
        S_EMIT: begin
          if (emit_go) begin
            held[chan]    <= held_new;
            rsp.chan_out  <= CHAN_W'(chan);
            rsp.level_out <= held_new;
            rsp.last_out  <= (chan == CW'(CHANNELS - 1));
            chan          <= chan + CW'(1);
            cand_idx      <= '0;
          end
        end
        default: begin
        end
      endcase
    end
  end

endmodule

### src/median_filter_with_hysteresis_top.sv
// Top level: register port, front end, command queue and filter engine.
//
//   channel  kind            accepted when
//   req      valid/ready     req_valid && req_ready
//   rsp      valid/ready     rsp_valid && rsp_ready
//   cfg      APB write       psel && penable && pwrite (pready tied high)
//
// A store is written as the engine pops it while idle. A filter request is popped
// and, per channel, each candidate sample is ranked by a sweep of the single read
// port of the sample RAM, stopping at the median.
// The four-entry command queue lets the front keep taking items during a filter.
// Reset clears the write slot, held levels and sample valid bits at once.
// A result waiting in the output register stalls the engine only at its next emit.
module median_filter_with_hysteresis_top import mfh_pkg::*; #(
  parameter int CHANNELS = 2,
  parameter int WINDOW   = 8
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        req_valid,
  output logic        req_ready,
  input  in_item_t    req,
  output logic        rsp_valid,
  input  logic        rsp_ready,
  output out_item_t   rsp,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam logic REG_HYST_HIGH = 1'b0;
  localparam logic REG_HYST_LOW  = 1'b1;

  cfg_t cfg;
  logic q_full;
  logic q_push;
  cmd_t q_cmd;
  logic q_pop;
  logic q_ready;
  cmd_t q_head;

  assign pready = 1'b1;

  always_comb begin
    unique case (paddr[2])
      REG_HYST_HIGH: prdata = {28'd0, cfg.hyst_high};
      REG_HYST_LOW:  prdata = {29'd0, cfg.hyst_low};
      default:       prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.hyst_high <= HYST_HIGH_RESET;
      cfg.hyst_low  <= HYST_LOW_RESET;
    end else if (psel && penable && pwrite && pready) begin
      unique case (paddr[2])
        REG_HYST_HIGH: cfg.hyst_high <= pwdata[3:0];
        REG_HYST_LOW:  cfg.hyst_low  <= pwdata[2:0];
        default: begin
        end
      endcase
    end
  end

  mfh_front #(
    .CHANNELS (CHANNELS),
    .WINDOW   (WINDOW)
  ) u_front (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .req       (req),
    .q_full    (q_full),
    .q_push    (q_push),
    .q_cmd     (q_cmd)
  );

  mfh_queue #(
    .DEPTH (4)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (q_push),
    .push_cmd  (q_cmd),
    .full      (q_full),
    .pop       (q_pop),
    .ready_out (q_ready),
    .head      (q_head)
  );

  mfh_back #(
    .CHANNELS (CHANNELS),
    .WINDOW   (WINDOW)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .q_ready   (q_ready),
    .q_head    (q_head),
    .q_pop     (q_pop),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .rsp       (rsp)
  );

endmodule

### bench/tb_median_filter_with_hysteresis_top.sv
// Testbench: random and directed sample stores and filter requests, checked against a level tracker.
`timescale 1ns / 100ps

module tb_median_filter_with_hysteresis_top;
  import mfh_pkg::*;

  localparam int CHANNELS      = 2;
  localparam int WINDOW        = 8;
  localparam int LEVEL_STEP    = 8;
  localparam int SAMPLE_MAX    = 4095;
  localparam int REG_HYST_HIGH = 0;
  localparam int REG_HYST_LOW  = 1;
  localparam int HOLD_OFF      = 2 * CHANNELS * (WINDOW * (WINDOW + 3) + 1);
  localparam int PHASE_ITEMS   = 75;

  class level_tracker;
    logic [SAMPLE_W-1:0] ring [CHANNELS][WINDOW];
    logic [LEVEL_W-1:0]  held [CHANNELS];
    int                  slot;
    logic [3:0]          hyst_high;
    logic [2:0]          hyst_low;
    out_item_t           pending_levels [$];
    int                  errors;

    function new();
      for (int c = 0; c < CHANNELS; c++) begin
        held[c] = '0;
        for (int s = 0; s < WINDOW; s++) ring[c][s] = '0;
      end
      slot      = 0;
      hyst_high = HYST_HIGH_RESET;
      hyst_low  = HYST_LOW_RESET;
      errors    = 0;
    endfunction

    function void write_reg(int idx, logic [31:0] value);
      if (idx == REG_HYST_HIGH) hyst_high = value[3:0];
      else if (idx == REG_HYST_LOW) hyst_low = value[2:0];
    endfunction

    function int median_of(int c);
      int vals [WINDOW];
      int j;
      int v;
      for (int i = 0; i < WINDOW; i++) vals[i] = ring[c][i];
      for (int i = 1; i < WINDOW; i++) begin
        v = vals[i];
        j = i - 1;
        while (j >= 0 && vals[j] > v) begin
          vals[j + 1] = vals[j];
          j--;
        end
        vals[j + 1] = v;
      end
      return vals[WINDOW / 2];
    endfunction

    function void note_item(in_item_t it);
      int        med;
      int        lvl;
      int        rem_v;
      out_item_t e;
      if (it.opcode == OP_STORE) begin
        if (it.chan_sel < CHANNELS) ring[it.chan_sel][slot] = it.sample_in;
        if (it.end_of_scan) slot = (slot == WINDOW - 1) ? 0 : slot + 1;
      end else begin
        for (int c = 0; c < CHANNELS; c++) begin
          med   = median_of(c);
          lvl   = med / LEVEL_STEP;
          rem_v = med % LEVEL_STEP;
          if (held[c] > lvl && rem_v < hyst_high) held[c] = LEVEL_W'(lvl);
          else if (held[c] < lvl && rem_v > hyst_low) held[c] = LEVEL_W'(lvl);
          e.chan_out  = CHAN_W'(c);
          e.level_out = held[c];
          e.last_out  = (c == CHANNELS - 1);
          pending_levels.push_back(e);
        end
      end
    endfunction

    task report(string msg);
      $display("mismatch at %0t: %s", $realtime, msg);
      errors++;
    endtask

    task check_level(out_item_t got);
      out_item_t e;
      if (pending_levels.size() == 0) begin
        report($sformatf("unexpected transfer chan %0d level %0d", got.chan_out, got.level_out));
      end else begin
        e = pending_levels.pop_front();
        if (got.chan_out !== e.chan_out)
          report($sformatf("chan_out %0d, want %0d", got.chan_out, e.chan_out));
        if (got.level_out !== e.level_out)
          report($sformatf("chan %0d level_out %0d, want %0d", e.chan_out, got.level_out,
                           e.level_out));
        if (got.last_out !== e.last_out)
          report($sformatf("chan %0d last_out %0b, want %0b", e.chan_out, got.last_out,
                           e.last_out));
      end
    endtask
  endclass

  logic        clk;
  logic        rst;
  logic        req_valid;
  logic        req_ready;
  in_item_t    req;
  logic        rsp_valid;
  logic        rsp_ready;
  out_item_t   rsp;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [2:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  level_tracker tracker;
  bit           steady;
  int           base_level [CHANNELS];

  median_filter_with_hysteresis_top #(
    .CHANNELS(CHANNELS),
    .WINDOW  (WINDOW)
  ) i_dut (
    .clk      (clk),
    .rst      (rst),
    .req_valid(req_valid),
    .req_ready(req_ready),
    .req      (req),
    .rsp_valid(rsp_valid),
    .rsp_ready(rsp_ready),
    .rsp      (rsp),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (steady || r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function int clamp_sample(int v);
    if (v < 0) return 0;
    if (v > SAMPLE_MAX) return SAMPLE_MAX;
    return v;
  endfunction

  function in_item_t store_item(int chan, int sample, bit eos);
    in_item_t it;
    it.opcode      = OP_STORE;
    it.chan_sel    = CHAN_W'(chan);
    it.sample_in   = SAMPLE_W'(sample);
    it.end_of_scan = eos;
    return it;
  endfunction

  function in_item_t filter_item();
    in_item_t it;
    it.opcode      = OP_FILTER;
    it.chan_sel    = CHAN_W'($urandom_range(0, 7));
    it.sample_in   = SAMPLE_W'($urandom_range(0, SAMPLE_MAX));
    it.end_of_scan = 1'($urandom_range(0, 1));
    return it;
  endfunction

  task send_item(in_item_t it);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      req_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    req_valid <= 1'b1;
    req       <= it;
    do @(negedge clk); while (!req_ready);
    @(posedge clk);
    tracker.note_item(it);
  endtask

  task write_reg(int idx, logic [31:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= 3'(idx * 4);
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    tracker.write_reg(idx, value);
  endtask

  task settle();
    req_valid <= 1'b0;
    while (tracker.pending_levels.size() != 0) @(posedge clk);
    repeat (HOLD_OFF) @(posedge clk);
  endtask

  task send_scan();
    int  first_eos;
    bit  broken;
    for (int c = 0; c < CHANNELS; c++) begin
      if ($urandom_range(0, 19) == 0) base_level[c] = $urandom_range(0, 1) * SAMPLE_MAX;
      else if ($urandom_range(0, 19) == 0) base_level[c] = $urandom_range(0, SAMPLE_MAX);
      else base_level[c] = clamp_sample(base_level[c] + $urandom_range(0, 16) - 8);
    end
    broken    = ($urandom_range(0, 9) == 0);
    first_eos = broken ? $urandom_range(0, CHANNELS) : CHANNELS - 1;
    for (int c = 0; c < CHANNELS; c++)
      send_item(store_item(c, clamp_sample(base_level[c] + $urandom_range(0, 6) - 3),
                           c == first_eos));
  endtask

  task run_phase(int n_items);
    int       sent;
    int       r;
    in_item_t it;
    sent = 0;
    while (sent < n_items) begin
      r = $urandom_range(0, 99);
      if (r < 12) begin
        it = ($bits(in_item_t))'($urandom);
        send_item(it);
        sent++;
      end else if (r < 32) begin
        send_item(filter_item());
        sent++;
      end else begin
        send_scan();
        sent += CHANNELS;
      end
    end
  endtask

  initial begin
    rsp_ready <= 1'b0;
    @(posedge clk);
    forever begin
      int        gap;
      out_item_t got;
      gap = pick_gap();
      if (gap > 0) begin
        rsp_ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      rsp_ready <= 1'b1;
      do @(negedge clk); while (!rsp_valid);
      got = rsp;
      @(posedge clk);
      tracker.check_level(got);
    end
  end

  initial begin
    #8_000_000;
    $display("FAIL");
    $finish;
  end

  initial begin
    tracker   = new();
    steady    = 1'b0;
    rst       <= 1'b1;
    req_valid <= 1'b0;
    req       <= '0;
    psel      <= 1'b0;
    penable   <= 1'b0;
    pwrite    <= 1'b0;
    paddr     <= '0;
    pwdata    <= '0;
    for (int c = 0; c < CHANNELS; c++) base_level[c] = $urandom_range(0, SAMPLE_MAX);
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // filter on an empty store, out-of-range channels, then full-scale levels
    send_item(filter_item());
    send_item(store_item(7, SAMPLE_MAX, 1'b1));
    send_item(store_item(2, 0, 1'b0));
    for (int k = 0; k < 5; k++) begin
      send_item(store_item(0, SAMPLE_MAX, 1'b0));
      send_item(store_item(1, 2050, 1'b1));
    end
    send_item(filter_item());
    send_item(filter_item());
    send_item(store_item(1, 7, 1'b0));
    settle();

    for (int p = 0; p < 6; p++) begin
      case (p)
        0: begin
          write_reg(REG_HYST_HIGH, 8);
          write_reg(REG_HYST_LOW, 7);
        end
        1: begin
          write_reg(REG_HYST_HIGH, 0);
          write_reg(REG_HYST_LOW, 0);
        end
        2: begin
          write_reg(REG_HYST_HIGH, 8);
          write_reg(REG_HYST_LOW, 0);
        end
        3: begin
          write_reg(REG_HYST_HIGH, 0);
          write_reg(REG_HYST_LOW, 7);
        end
        4: begin
          write_reg(REG_HYST_HIGH, 32'(HYST_HIGH_RESET));
          write_reg(REG_HYST_LOW, 32'(HYST_LOW_RESET));
        end
        default: begin
          write_reg(REG_HYST_HIGH, $urandom_range(0, 8));
          write_reg(REG_HYST_LOW, $urandom_range(0, 7));
        end
      endcase
      steady = (p == 2);
      run_phase(PHASE_ITEMS);
      settle();
    end

    if (tracker.errors == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
